// File: hw/rtl/glf_pkg.sv
// Shared types, widths and register codes for the clamped-edge Gaussian line filter.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package glf_pkg;

    // Sizing
    localparam int MAX_RADIUS    = 3;
    localparam int SAMPLE_BITS   = 16;
    localparam int WIN_LEN       = 2 * MAX_RADIUS + 1;
    localparam int RAD_BITS      = $clog2(MAX_RADIUS + 1);
    localparam int CFG_RAD_BITS  = 2;
    localparam int WEIGHT_BITS   = 17;
    localparam int NUM_WEIGHTS   = 4;
    localparam int FRAC_BITS     = 16;
    localparam int PAIR_BITS     = SAMPLE_BITS + 1;
    localparam int PROD_BITS     = PAIR_BITS + WEIGHT_BITS;
    localparam int ACC_BITS      = PROD_BITS + $clog2(MAX_RADIUS + 2);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = WEIGHT_BITS;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS       = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_CENTER = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_ONE   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_TWO   = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_THREE = CFG_IDX_BITS'(4);

    // Register reset values
    localparam logic [CFG_RAD_BITS-1:0] RADIUS_RESET       = CFG_RAD_BITS'(2);
    localparam logic [WEIGHT_BITS-1:0]  WEIGHT_CENTER_RESET = WEIGHT_BITS'(26942);
    localparam logic [WEIGHT_BITS-1:0]  WEIGHT_ONE_RESET   = WEIGHT_BITS'(15925);
    localparam logic [WEIGHT_BITS-1:0]  WEIGHT_TWO_RESET   = WEIGHT_BITS'(3532);
    localparam logic [WEIGHT_BITS-1:0]  WEIGHT_THREE_RESET = WEIGHT_BITS'(0);

    // Rounding constant: one half in Q0.16
    localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    typedef logic [SAMPLE_BITS-1:0]                  sample_t;
    typedef logic [WEIGHT_BITS-1:0]                  weight_t;
    typedef logic [RAD_BITS-1:0]                     radius_t;
    typedef logic [WIN_LEN-1:0][SAMPLE_BITS-1:0]     window_t;
    typedef logic [MAX_RADIUS:0][WEIGHT_BITS-1:0]    tap_weights_t;

    typedef struct packed {
        sample_t sample_in;
        logic    line_end_in;
    } in_item_t;

    typedef struct packed {
        sample_t sample_out;
        logic    line_end_out;
    } out_item_t;

    // Window status handed to the multiply-accumulate pipeline
    typedef struct packed {
        logic emit;
        logic last;
    } win_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/gaussian_line_filter_clamped.sv
// Top level of the clamped-edge Gaussian line filter: config registers, window
// control and the cell row. Depends on glf_pkg, glf_cell and glf_mac.
`default_nettype none

// One axis pass of a separable Gaussian blur. Samples arrive one item per cycle
// while in_ready is high, in line order, with line_end_in on the last sample of
// each line. The window is a row of 2*MAX_RADIUS+1 cells; the first sample of a
// line fills every cell (left edge replicated) and later samples shift in at the
// top. Results lag the input by radius samples, and a line of L samples gives L
// results, the last one marked with line_end_out. Throughput is one item per
// cycle while the result path does not stall, except that after a line-end item
// the input is held while the cell row shifts the last sample in again to flush
// the right edge. The window loads at the edge that accepts an item or flush
// step; its result then passes the product register and the output register
// before it is offered. No clearing pass is needed after reset. Weights are
// unsigned Q1.16; each sum is rounded half up and saturated to 16 bits.
// Configuration writes must only happen while the block is idle.
module gaussian_line_filter_clamped
    import glf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire in_item_t                 in_item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output out_item_t                     out_item,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [CFG_RAD_BITS-1:0] radius_cfg_reg;
    weight_t                 wcfg_reg [NUM_WEIGHTS];
    radius_t                 radius_eff;
    tap_weights_t            tap_w;

    window_t                 window;
    sample_t                 shift_value;
    logic                    win_step;
    logic                    win_fill;
    logic                    in_fire;
    logic                    flush_step;
    logic                    adv_w;
    logic                    mac_ready;
    win_ctrl_t               win_ctrl;

    logic                    emit_reg, emit_next;
    logic                    last_reg, last_next;
    logic                    flush_reg, flush_next;
    radius_t                 fill_reg, fill_next;
    radius_t                 j_reg, j_next;
    radius_t                 n_reg, n_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_cfg_reg <= RADIUS_RESET;
            wcfg_reg[0]    <= WEIGHT_CENTER_RESET;
            wcfg_reg[1]    <= WEIGHT_ONE_RESET;
            wcfg_reg[2]    <= WEIGHT_TWO_RESET;
            wcfg_reg[3]    <= WEIGHT_THREE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS:        radius_cfg_reg <= cfg_data[CFG_RAD_BITS-1:0];
                REG_WEIGHT_CENTER: wcfg_reg[0]    <= cfg_data;
                REG_WEIGHT_ONE:    wcfg_reg[1]    <= cfg_data;
                REG_WEIGHT_TWO:    wcfg_reg[2]    <= cfg_data;
                REG_WEIGHT_THREE:  wcfg_reg[3]    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Clip radius to the window size
    always_comb
    begin
        if (int'(radius_cfg_reg) > MAX_RADIUS)
        begin
            radius_eff = RAD_BITS'(MAX_RADIUS);
        end
        else
        begin
            radius_eff = RAD_BITS'(radius_cfg_reg);
        end
    end

    // Taps beyond the configured distances weigh zero
    for (genvar d = 0; d <= MAX_RADIUS; d++)
    begin : g_tap_w
        if (d < NUM_WEIGHTS)
        begin : g_cfg
            assign tap_w[d] = wcfg_reg[d];
        end
        else
        begin : g_zero
            assign tap_w[d] = '0;
        end
    end

    // Handshake and window stepping
    assign adv_w       = !emit_reg || mac_ready;
    assign in_ready    = adv_w && !flush_reg;
    assign in_fire     = in_valid && in_ready;
    assign flush_step  = flush_reg && adv_w;
    assign win_step    = in_fire || flush_step;
    assign win_fill    = in_fire && (fill_reg == '0);
    assign shift_value = flush_reg ? window[WIN_LEN-1] : in_item.sample_in;

    // Row of cells, each taking its upper neighbour's sample
    for (genvar k = 0; k < WIN_LEN; k++)
    begin : g_cell
        sample_t neighbour;
        if (k == WIN_LEN - 1)
        begin : g_top
            assign neighbour = shift_value;
        end
        else
        begin : g_inner
            assign neighbour = window[k+1];
        end

        glf_cell u_cell (
            .clk         (clk),
            .step        (win_step),
            .fill        (win_fill),
            .fill_value  (in_item.sample_in),
            .shift_value (neighbour),
            .value       (window[k])
        );
    end

    // Line position, flush sequencing and emit marking
    always_comb
    begin
        emit_next  = emit_reg;
        last_next  = last_reg;
        flush_next = flush_reg;
        fill_next  = fill_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        if (in_fire)
        begin
            emit_next = fill_reg >= radius_eff;
            last_next = in_item.line_end_in && (radius_eff == '0);
            if (in_item.line_end_in)
            begin
                fill_next = '0;
                if (radius_eff != '0)
                begin
                    flush_next = 1'b1;
                    j_next     = RAD_BITS'(1);
                    n_next     = fill_reg;
                end
            end
            else if (fill_reg != RAD_BITS'(MAX_RADIUS))
            begin
                fill_next = fill_reg + RAD_BITS'(1);
            end
        end
        else if (flush_step)
        begin
            emit_next = ({1'b0, j_reg} + {1'b0, n_reg}) >= {1'b0, radius_eff};
            last_next = j_reg == radius_eff;
            if (j_reg == radius_eff)
            begin
                flush_next = 1'b0;
            end
            else
            begin
                j_next = j_reg + RAD_BITS'(1);
            end
        end
        else if (adv_w)
        begin
            emit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg  <= 1'b0;
            last_reg  <= 1'b0;
            flush_reg <= 1'b0;
            fill_reg  <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            emit_reg  <= emit_next;
            last_reg  <= last_next;
            flush_reg <= flush_next;
            fill_reg  <= fill_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
        end
    end

    assign win_ctrl.emit = emit_reg;
    assign win_ctrl.last = last_reg;

    glf_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .ready     (mac_ready),
        .window    (window),
        .radius    (radius_eff),
        .tap_w     (tap_w),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    // Flush position stays within the radius
    a_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (j_reg != '0) && (j_reg <= radius_eff))
        else $error("flush position out of range");

    // Line position saturates at the window half width
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= RAD_BITS'(MAX_RADIUS))
        else $error("line position beyond window half width");

    // A line end with nonzero radius starts a flush
    a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_item.line_end_in && (radius_eff != '0)) |=> flush_reg)
        else $error("line end did not start a flush");

    // A line end with nonzero radius marks its result only at the last flush step
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_reg && last_reg && (radius_eff != '0)) |-> !flush_reg)
        else $error("line end marked before flush finished");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/glf_cell.sv
// One delay-line cell of the line filter window: holds a single sample.
// Depends on glf_pkg for the sample type.
`default_nettype none

module glf_cell
    import glf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    step,
    input  wire logic    fill,
    input  wire sample_t fill_value,
    input  wire sample_t shift_value,
    output sample_t      value
);

    sample_t value_reg;

    // Load the line's first sample or take the neighbour's sample
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            value_reg <= fill ? fill_value : shift_value;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: hw/rtl/glf_mac.sv
// Tap selection, pair multiply, sum, rounding and saturation for the line filter,
// with an output register towards the result channel. Depends on glf_pkg.
`default_nettype none

module glf_mac
    import glf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire win_ctrl_t    ctrl,
    output logic              ready,
    input  wire window_t      window,
    input  wire radius_t      radius,
    input  wire tap_weights_t tap_w,
    output logic              out_valid,
    input  wire logic         out_ready,
    output out_item_t         out_item
);

    logic [MAX_RADIUS:0][PAIR_BITS-1:0] pair;
    logic [MAX_RADIUS:0][PROD_BITS-1:0] prod_next;
    logic [MAX_RADIUS:0][PROD_BITS-1:0] prod_reg;
    logic                               b_valid_reg;
    logic                               b_last_reg;
    logic                               b_ready;
    logic [ACC_BITS-1:0]                acc;
    logic                               sat;
    out_item_t                          o_item_next;
    out_item_t                          o_item_reg;
    logic                               o_valid_reg;

    assign b_ready = !o_valid_reg || out_ready;
    assign ready   = !b_valid_reg || b_ready;

    // Pick centre and mirrored pairs around the centre for the active radius
    always_comb
    begin
        pair = '0;
        for (int rr = 0; rr <= MAX_RADIUS; rr++)
        begin
            if (radius == RAD_BITS'(rr))
            begin
                pair[0] = {1'b0, window[WIN_LEN-1-rr]};
                for (int d = 1; d <= rr; d++)
                begin
                    pair[d] = {1'b0, window[WIN_LEN-1-rr-d]}
                            + {1'b0, window[WIN_LEN-1-rr+d]};
                end
            end
        end
    end

    // One multiplier per tap distance
    always_comb
    begin
        for (int d = 0; d <= MAX_RADIUS; d++)
        begin
            prod_next[d] = pair[d] * tap_w[d];
        end
    end

    // Product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            b_valid_reg <= ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && ctrl.emit)
        begin
            prod_reg   <= prod_next;
            b_last_reg <= ctrl.last;
        end
    end

    // Sum products, round half up, saturate to the sample range
    always_comb
    begin
        acc = ROUND_HALF;
        for (int d = 0; d <= MAX_RADIUS; d++)
        begin
            acc = acc + ACC_BITS'(prod_reg[d]);
        end
        sat = |acc[ACC_BITS-1:FRAC_BITS+SAMPLE_BITS];
        o_item_next.sample_out   = sat ? {SAMPLE_BITS{1'b1}}
                                       : acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
        o_item_next.line_end_out = b_last_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && b_valid_reg)
        begin
            o_item_reg <= o_item_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_item_reg;

endmodule

`default_nettype wire

// File: tb/gaussian_line_filter_clamped_test.sv
// Self-checking testbench for the clamped-edge Gaussian line filter: directed edge lines,
// then random lines under random weights, checked against an in-bench line predictor.
// Depends on glf_pkg and the gaussian_line_filter_clamped RTL.
module gaussian_line_filter_clamped_test
    import glf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 10;
    localparam int RANDOM_ITEMS = 430;
    localparam int REPORT_MAX   = 10;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;
    typedef enum {LINE_NOISE, LINE_EXTREMES, LINE_RAMP, LINE_FLAT} line_style_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    in_item_t                 in_item   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_item_t                out_item;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // Predictor copy of the configuration and of the line state
    logic [CFG_RAD_BITS-1:0] model_radius;
    weight_t                 model_weight [NUM_WEIGHTS];
    sample_t                 line_window [WIN_LEN];
    int unsigned             line_fill;

    in_item_t    pending_items [$];
    out_item_t   expected_q [$];
    int unsigned issued_count;
    int unsigned accepted_count;
    int unsigned result_count;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    out_item_t   monitor_want;

    int unsigned burst_left;
    int unsigned gap_left;
    ready_mode_t stall_mode;
    int unsigned stall_stretch;
    int unsigned stall_phase;

    gaussian_line_filter_clamped i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shift one sample in at the newest end of the window
    function automatic void shift_window(sample_t value);
        int k;
        for (k = 0; k < WIN_LEN - 1; k++)
        begin
            line_window[k] = line_window[k + 1];
        end
        line_window[WIN_LEN - 1] = value;
    endfunction

    // Weighted sum around the tap radius samples below the newest, rounded half up and saturated
    function automatic sample_t smooth_at(int unsigned r);
        int          c;
        int          d;
        logic [63:0] acc;
        c = WIN_LEN - 1 - int'(r);
        acc = 64'(line_window[c]) * 64'(model_weight[0]);
        for (d = 1; d <= int'(r); d++)
        begin
            acc += (64'(line_window[c - d]) + 64'(line_window[c + d])) * 64'(model_weight[d]);
        end
        acc = (acc + 64'(32768)) >> FRAC_BITS;
        return (acc > 64'(16'hFFFF)) ? '1 : sample_t'(acc);
    endfunction

    // Work out the results that one accepted item causes and queue them
    function automatic void predict_step(in_item_t item);
        int unsigned r;
        int unsigned n;
        int unsigned j;
        int          k;
        out_item_t   res;
        r = (model_radius > MAX_RADIUS) ? MAX_RADIUS : model_radius;
        n = line_fill;
        if (n == 0)
        begin
            // first sample of a line fills the left border
            for (k = 0; k < WIN_LEN; k++)
            begin
                line_window[k] = item.sample_in;
            end
        end
        else
        begin
            shift_window(item.sample_in);
        end
        if (n >= r)
        begin
            res.sample_out   = smooth_at(r);
            res.line_end_out = item.line_end_in && (r == 0);
            expected_q.push_back(res);
        end
        if (!item.line_end_in)
        begin
            line_fill = (n + 1 > MAX_RADIUS) ? MAX_RADIUS : n + 1;
        end
        else
        begin
            // flush with the last sample replicated to the right
            for (j = 1; j <= r; j++)
            begin
                shift_window(item.sample_in);
                if (j + n >= r)
                begin
                    res.sample_out   = smooth_at(r);
                    res.line_end_out = (j == r);
                    expected_q.push_back(res);
                end
            end
            line_fill = 0;
        end
    endfunction

    // Sender: bursts of random length with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left = burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a pattern that changes every stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            stall_mode    = READY_ALWAYS;
            stall_stretch = 0;
            stall_phase   = 0;
        end
        else
        begin
            if (stall_stretch == 0)
            begin
                stall_mode    = ready_mode_t'($urandom_range(0, 3));
                stall_stretch = $urandom_range(16, 160);
            end
            else
            begin
                stall_stretch = stall_stretch - 1;
            end
            stall_phase = stall_phase + 1;
            case (stall_mode)
                READY_ALWAYS: out_ready <= 1'b1;
                READY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
                READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:      out_ready <= ((stall_phase % 5) < 3);
            endcase
        end
    end

    // Monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_step(in_item);
                accepted_count = accepted_count + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                        $display("result %0d with nothing expected: sample_out %0d line_end_out %0b",
                                 result_count, out_item.sample_out, out_item.line_end_out);
                end
                else
                begin
                    monitor_want = expected_q.pop_front();
                    if (out_item.sample_out !== monitor_want.sample_out ||
                        out_item.line_end_out !== monitor_want.line_end_out)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_MAX)
                            $display("result %0d: expected sample_out %0d line_end_out %0b, got %0d %0b",
                                     result_count, monitor_want.sample_out,
                                     monitor_want.line_end_out, out_item.sample_out,
                                     out_item.line_end_out);
                    end
                end
                result_count = result_count + 1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[gaussian_line_filter_clamped] ERROR");
            $finish;
        end
    end

    task automatic send_item(sample_t value, logic last);
        in_item_t item;
        item.sample_in   = value;
        item.line_end_in = last;
        pending_items.push_back(item);
        issued_count = issued_count + 1;
    endtask

    // Hold until every item is taken and every result has come, then let the pipe settle
    task automatic wait_drained();
        while (accepted_count != issued_count || expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            REG_RADIUS:        model_radius    = data[CFG_RAD_BITS-1:0];
            REG_WEIGHT_CENTER: model_weight[0] = data;
            REG_WEIGHT_ONE:    model_weight[1] = data;
            REG_WEIGHT_TWO:    model_weight[2] = data;
            REG_WEIGHT_THREE:  model_weight[3] = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [CFG_RAD_BITS-1:0] r, weight_t wc, weight_t w1,
                                  weight_t w2, weight_t w3);
        write_reg(REG_RADIUS, CFG_DATA_BITS'(r));
        write_reg(REG_WEIGHT_CENTER, wc);
        write_reg(REG_WEIGHT_ONE, w1);
        write_reg(REG_WEIGHT_TWO, w2);
        write_reg(REG_WEIGHT_THREE, w3);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned phase_target;
        int unsigned phase_items;
        int unsigned line_len;
        int unsigned k;
        int unsigned room;
        int          ramp_step;
        line_style_t style;
        sample_t     base;
        sample_t     value;
        logic        close_line;
        logic [CFG_RAD_BITS-1:0] r_pick;
        weight_t     wc;
        weight_t     w1;
        weight_t     w2;
        weight_t     w3;

        // Predictor starts from the reset state
        model_radius    = RADIUS_RESET;
        model_weight[0] = WEIGHT_CENTER_RESET;
        model_weight[1] = WEIGHT_ONE_RESET;
        model_weight[2] = WEIGHT_TWO_RESET;
        model_weight[3] = WEIGHT_THREE_RESET;
        for (k = 0; k < WIN_LEN; k++)
        begin
            line_window[k] = '0;
        end
        line_fill      = 0;
        issued_count   = 0;
        accepted_count = 0;
        result_count   = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        random_items   = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset weights: one-sample line at full scale, then an alternating line
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b1);
        wait_drained();

        // Radius zero: pass-through, no flush results
        apply_settings(2'd0, 17'd65536, 17'd0, 17'd0, 17'd0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hAAAA, 1'b1);
        send_item(16'h5555, 1'b1);
        wait_drained();

        // Largest radius with weights at or above unity: saturation
        apply_settings(2'd3, 17'h1FFFF, 17'd65536, 17'd65536, 17'd65536);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'hFFFF, 1'b1);
        wait_drained();

        // Radius one, two-sample line with quarter fractions to round
        apply_settings(2'd1, 17'd32768, 17'd16384, 17'd0, 17'd0);
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b1);
        wait_drained();

        // Radius raised in the middle of a line
        apply_settings(2'd1, 17'd26942, 17'd15925, 17'd3532, 17'd0);
        send_item(16'd100, 1'b0);
        send_item(16'd200, 1'b0);
        wait_drained();
        apply_settings(2'd3, 17'd20000, 17'd12000, 17'd6000, 17'd4768);
        send_item(16'd300, 1'b0);
        send_item(16'd400, 1'b1);
        wait_drained();

        // Radius dropped in the middle of a line
        send_item(16'd500, 1'b0);
        send_item(16'd600, 1'b0);
        send_item(16'd700, 1'b0);
        send_item(16'd800, 1'b0);
        wait_drained();
        apply_settings(2'd0, 17'd0, 17'd0, 17'd0, 17'd0);
        send_item(16'd900, 1'b1);
        wait_drained();

        // Random phases: fresh settings, then lines of random shape and length
        while (random_items < RANDOM_ITEMS)
        begin
            r_pick = ($urandom_range(0, 7) == 0) ? 2'd0 : CFG_RAD_BITS'($urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0)
            begin
                wc = weight_t'($urandom_range(0, 131071));
                w1 = weight_t'($urandom_range(0, 131071));
                w2 = weight_t'($urandom_range(0, 131071));
                w3 = weight_t'($urandom_range(0, 131071));
            end
            else
            begin
                // roughly normalised kernel
                room = $urandom_range(8192, 65536);
                wc   = weight_t'(room);
                room = 65536 - room;
                w1   = weight_t'($urandom_range(0, room / 2));
                room = room - 2 * int'(w1);
                w2   = weight_t'($urandom_range(0, room / 2));
                room = room - 2 * int'(w2);
                w3   = weight_t'(room / 2);
            end
            apply_settings(r_pick, wc, w1, w2, w3);

            phase_target = $urandom_range(20, 60);
            phase_items  = 0;
            while (phase_items < phase_target)
            begin
                line_len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 8);
                // leave the phase's last line open now and then
                close_line = (phase_items + line_len < phase_target) ||
                             ($urandom_range(0, 4) != 0);
                style      = line_style_t'($urandom_range(0, 3));
                base       = sample_t'($urandom);
                ramp_step  = int'($urandom_range(0, 4000)) - 2000;
                for (k = 0; k < line_len; k++)
                begin
                    case (style)
                        LINE_NOISE:    value = sample_t'($urandom);
                        LINE_EXTREMES: value = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                        LINE_RAMP:     value = base + sample_t'(ramp_step * int'(k));
                        default:       value = base + sample_t'($urandom_range(0, 63));
                    endcase
                    send_item(value, close_line && (k == line_len - 1));
                end
                phase_items = phase_items + line_len;
            end
            random_items = random_items + phase_items;
            wait_drained();
        end

        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("[gaussian_line_filter_clamped] OK");
        else
            $display("[gaussian_line_filter_clamped] ERROR");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/glf_pkg.sv
hw/rtl/glf_cell.sv
hw/rtl/glf_mac.sv
hw/rtl/gaussian_line_filter_clamped.sv
tb/gaussian_line_filter_clamped_test.sv
